// ===== design/bounded_stack_with_reverse_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bounded stack core.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_REVERSE_CORE_MACROS_SVH
`define BOUNDED_STACK_WITH_REVERSE_CORE_MACROS_SVH

// Checks a condition that must hold in the same cycle as its trigger.
`define BSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a condition that must hold in the cycle after its trigger.
`define BSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bsr_pkg.sv =====
// ---------------------------------------------------------------------------
// bsr_pkg
// Shared codes and controller/datapath signal groups for the stack core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsr_pkg;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_PUSH     = 3'd0;
  localparam logic [2:0] MODE_POP      = 3'd1;
  localparam logic [2:0] MODE_PEEK     = 3'd2;
  localparam logic [2:0] MODE_POP_READ = 3'd3;
  localparam logic [2:0] MODE_REVERSE  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       ld_item;   // capture the incoming beat
    logic       wr_push;   // write the pushed value on top
    logic       cnt_inc;
    logic       cnt_dec;
    logic       rd_top;    // read the top entry
    logic       sw_init;   // set up the swap pointers
    logic       sw_rd;     // read both swap entries
    logic       sw_wr_lo;  // write the low swap entry
    logic       sw_wr_hi;  // write the high swap entry, step the pointers
    logic       st_we;     // overwrite the result status
    logic [1:0] st_code;
    logic       ld_rd;     // take the read data into the result
    logic       out_load;  // move the result into the output register
  } bsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       empty;
    logic       full;
    logic       few;        // fewer than two entries held
    logic       more_pairs; // another pair remains after the current swap
    logic       out_free;   // output register can take a result
  } bsr_sts_t;

endpackage

// ===== design/bsr_if.sv =====
// ---------------------------------------------------------------------------
// bsr_in_if / bsr_out_if
// Valid/ready channels for stack requests and results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsr_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  mode;
  logic signed [31:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface bsr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic        [1:0]  status;
  logic        [4:0]  held_count;

  modport source (output valid, output read_value, output status,
                  output held_count, input ready);
  modport sink   (input valid, input read_value, input status,
                  input held_count, output ready);
endinterface

// ===== design/bsr_ctrl.sv =====
// ---------------------------------------------------------------------------
// bsr_ctrl
// Sequencer for the stack: decodes each beat and steps the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsr_ctrl
  import bsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bsr_sts_t sts,
  output bsr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SW_RD  = 3'd3;
  localparam logic [2:0] S_SW_LO  = 3'd4;
  localparam logic [2:0] S_SW_HI  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st_code = ST_OK;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (sts.mode)
          MODE_PUSH: begin
            if (sts.full) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.wr_push = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
          end
          MODE_POP: begin
            if (sts.empty) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_EMPTY;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          MODE_PEEK, MODE_POP_READ: begin
            if (sts.empty) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_EMPTY;
            end else begin
              cmd.rd_top  = 1'b1;
              cmd.cnt_dec = (sts.mode == MODE_POP_READ);
              state_nxt   = S_RDWAIT;
            end
          end
          MODE_REVERSE: begin
            if (!sts.few) begin
              cmd.sw_init = 1'b1;
              state_nxt   = S_SW_RD;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.ld_rd = 1'b1;
        state_nxt = S_FINISH;
      end
      S_SW_RD: begin
        cmd.sw_rd = 1'b1;
        state_nxt = S_SW_LO;
      end
      S_SW_LO: begin
        cmd.sw_wr_lo = 1'b1;
        state_nxt    = S_SW_HI;
      end
      S_SW_HI: begin
        cmd.sw_wr_hi = 1'b1;
        state_nxt    = sts.more_pairs ? S_SW_RD : S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/bsr_dpath.sv =====
// ---------------------------------------------------------------------------
// bsr_dpath
// Stack storage, fill count, swap pointers and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsr_dpath
  import bsr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic        [2:0]  in_mode,
  input  logic signed [31:0] in_push_value,
  input  bsr_cmd_t           cmd,
  output bsr_sts_t           sts,
  bsr_out_if.source          out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic        [2:0]  mode_r;
  logic signed [31:0] val_r;
  logic        [CW-1:0] cnt_r, cnt_nxt;
  logic        [CW-1:0] cnt_m1;
  logic        [AW-1:0] top_idx, push_idx;
  logic        [AW-1:0] lo_r, hi_r;
  logic        [AW:0]   span;
  logic        [31:0] mem_r [DEPTH];
  logic        [31:0] rda_r, rdb_r;
  logic        [AW-1:0] ra, wa;
  logic        [31:0] wd;
  logic               we, rd_en;
  logic        [31:0] res_rd_r;
  logic        [1:0]  res_st_r;
  logic               out_valid_r, out_valid_nxt;
  logic        [31:0] out_rd_r;
  logic        [1:0]  out_st_r;
  logic        [4:0]  out_cnt_r;

  // Address helpers.
  assign cnt_m1   = cnt_r - CW'(1);
  assign top_idx  = cnt_m1[AW-1:0];
  assign push_idx = cnt_r[AW-1:0];
  assign span     = {1'b0, hi_r} - {1'b0, lo_r};

  // Status toward the controller.
  always_comb begin
    sts.mode       = mode_r;
    sts.empty      = (cnt_r == '0);
    sts.full       = (cnt_r == CW'(DEPTH));
    sts.few        = (cnt_r < CW'(2));
    sts.more_pairs = (span > (AW + 1)'(2));
    sts.out_free   = !out_valid_r || out_ch.ready;
  end

  // Captured beat.
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      mode_r <= in_mode;
      val_r  <= in_push_value;
    end
  end

  // Fill count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Swap pointers walk inward from both ends.
  always_ff @(posedge clk) begin
    if (cmd.sw_init) begin
      lo_r <= '0;
      hi_r <= top_idx;
    end else if (cmd.sw_wr_hi) begin
      lo_r <= lo_r + AW'(1);
      hi_r <= hi_r - AW'(1);
    end
  end

  // Memory port selection.
  always_comb begin
    rd_en = cmd.rd_top || cmd.sw_rd;
    ra    = cmd.rd_top ? top_idx : lo_r;
    we    = cmd.wr_push || cmd.sw_wr_lo || cmd.sw_wr_hi;
    if (cmd.wr_push) begin
      wa = push_idx;
      wd = val_r;
    end else if (cmd.sw_wr_lo) begin
      wa = lo_r;
      wd = rdb_r;
    end else begin
      wa = hi_r;
      wd = rda_r;
    end
  end

  // Stack storage: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (rd_en) begin
      rda_r <= mem_r[ra];
      rdb_r <= mem_r[hi_r];
    end
  end

  // Result staging for the item in progress.
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      res_rd_r <= '0;
      res_st_r <= ST_OK;
    end else begin
      if (cmd.st_we) begin
        res_st_r <= cmd.st_code;
      end
      if (cmd.ld_rd) begin
        res_rd_r <= rda_r;
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rd_r  <= res_rd_r;
      out_st_r  <= res_st_r;
      out_cnt_r <= 5'(cnt_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.held_count = out_cnt_r;

endmodule

// ===== design/bounded_stack_with_reverse_core.sv =====
// ---------------------------------------------------------------------------
// bounded_stack_with_reverse_core
// Bounded LIFO stack of 32-bit words with push, pop, peek, pop-read and
// in-place reverse.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request beat (mode, push_value); out_ch returns one
//   result beat (read_value, status, held_count) for every request.
//   Requests are taken one at a time; in_ch.ready is high only while the
//   sequencer is idle.
//   After acceptance the sequencer steps through decode to finish, where
//   the result is loaded into the output register that drives out_ch.valid;
//   peek and pop-read pass a read-wait state in between, and reverse of n
//   held words runs floor(n / 2) swap passes. Ready returns in the cycle
//   after the result is loaded. Swaps are paced by the single write port of
//   the stack storage: each pair is read, then the low and the high entry are written.
//   A full stack on push or an empty stack on a read leaves the contents
//   untouched and reports it in status.
//   Reset clears the fill count and the output register; storage contents
//   are not cleared, since only written entries are ever read.
//   When out_ch.ready is low the result holds in the output register and
//   a new request may still be accepted; the sequencer waits at the end of
//   that request until the register frees up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bounded_stack_with_reverse_core_macros.svh"

module bounded_stack_with_reverse_core
  import bsr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bsr_in_if.sink     in_ch,
  bsr_out_if.source  out_ch
);

  bsr_cmd_t cmd;
  bsr_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  bsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and result path.
  bsr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_ch.mode),
    .in_push_value (in_ch.push_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_ch        (out_ch)
  );

  // Checks on the controller and datapath handoff.
  `BSR_ASSERT_NOW(a_push_not_full, cmd.wr_push, !sts.full, "push written into a full stack")
  `BSR_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free, "result loaded over a pending beat")
  `BSR_ASSERT_NOW(a_one_writer, cmd.wr_push, !(cmd.sw_wr_lo || cmd.sw_wr_hi), "write port conflict")
  `BSR_ASSERT_NEXT(a_busy_after_take, in_ch.valid && in_ch.ready, !in_ch.ready, "second beat taken while busy")

endmodule
